/* sv/sps_pkg.sv */
// Package for the H.264 SPS size and rate parser: syntax step codes, field widths,
// branch flag bits and the controller command type. No dependencies.
`default_nettype none
package sps_pkg;
    localparam int MAX_PREFIX_ZEROS = 31;
    localparam int MAX_POC_CYCLE    = 255;

    localparam logic [5:0] ST_HDR = 6'd0, ST_PROFILE = 6'd1, ST_CONSTR = 6'd2,
        ST_LEVEL = 6'd3, ST_SPSID = 6'd4, ST_CHROMA = 6'd5, ST_RESCOL = 6'd6,
        ST_BDL = 6'd7, ST_BDC = 6'd8, ST_BYPASS = 6'd9, ST_SMAT = 6'd10,
        ST_SLIST = 6'd11, ST_LOG2FN = 6'd12, ST_POCT = 6'd13, ST_POCLSB = 6'd14,
        ST_DPOAZ = 6'd15, ST_ONRP = 6'd16, ST_OTTB = 6'd17, ST_NCYC = 6'd18,
        ST_OFFREF = 6'd19, ST_NREF = 6'd20, ST_GAPS = 6'd21, ST_WIDTH = 6'd22,
        ST_HEIGHT = 6'd23, ST_FMBS = 6'd24, ST_MBAFF = 6'd25, ST_D8 = 6'd26,
        ST_CROP = 6'd27, ST_CROPOFF = 6'd28, ST_VUI = 6'd29, ST_ARP = 6'd30,
        ST_ARIDC = 6'd31, ST_SARW = 6'd32, ST_SARH = 6'd33, ST_OSP = 6'd34,
        ST_OSA = 6'd35, ST_VST = 6'd36, ST_VFMT = 6'd37, ST_VFR = 6'd38,
        ST_CDP = 6'd39, ST_COLOR = 6'd40, ST_CLOC = 6'd41, ST_CLOCV = 6'd42,
        ST_TIM = 6'd43, ST_TICK = 6'd44, ST_SCALE = 6'd45, ST_DONE = 6'd46;

    localparam logic [1:0] STS_OK = 2'd0, STS_NOT_SPS = 2'd1, STS_TRUNC = 2'd2,
        STS_SCALING = 2'd3;

    localparam int FL_HIGH = 0, FL_C444 = 1, FL_SIZE = 2, FL_RATE = 3;

    // field width per syntax step, 0 means exp-Golomb
    function automatic logic [5:0] step_bits(input logic [5:0] s);
        logic [5:0] r;
        unique case (s)
            ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_ARIDC: r = 6'd8;
            ST_SARW, ST_SARH: r = 6'd16;
            ST_VFMT: r = 6'd3;
            ST_COLOR: r = 6'd24;
            ST_TICK, ST_SCALE: r = 6'd32;
            ST_SPSID, ST_CHROMA, ST_BDL, ST_BDC, ST_LOG2FN, ST_POCT, ST_POCLSB,
            ST_ONRP, ST_OTTB, ST_NCYC, ST_OFFREF, ST_NREF, ST_WIDTH, ST_HEIGHT,
            ST_CROPOFF, ST_CLOCV: r = 6'd0;
            default: r = 6'd1;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic load;   // take a new byte into the bit shifter
        logic shift;  // feed the top bit to the syntax walker
        logic clear;  // back to reset state
        logic div_start;
    } sps_cmd_t;
endpackage
`default_nettype wire

/* sv/sps_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module sps_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [32:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [33:0] trial;

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        trial    = {rem_reg, q_reg[31]} - {1'b0, dvs_reg};
        if (start) begin
            cnt_next = 6'd32;
            rem_next = '0;
            q_next   = dividend;
            dvs_next = divisor;
        end else if (cnt_reg != 6'd0) begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[33]) begin
                rem_next = trial[32:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], q_reg[31]};
                q_next   = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != 6'd0;
    assign quotient = q_reg;
endmodule
`default_nettype wire

/* sv/sps_datapath.sv */
// Datapath: bit shifter with emulation-prevention drop, syntax walker with
// exp-Golomb reader, and parsed size/timing registers. Uses sps_pkg.
`default_nettype none
module sps_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sps_pkg::sps_cmd_t cmd,
    input  wire logic [7:0]    in_byte,
    output logic [3:0]         bits_left,
    output logic [1:0]         status,
    output logic [20:0]        width_px,
    output logic [20:0]        height_px,
    output logic [31:0]        scale,
    output logic [32:0]        tick2,
    output logic               rate_ok
);
    import sps_pkg::*;

    logic [1:0]  zero_run_reg, zero_run_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  nb_reg, nb_next;
    logic [5:0]  step_reg, step_next;
    logic        phase_reg, phase_next;
    logic [5:0]  pz_reg, pz_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  rem_reg, rem_next;
    logic [7:0]  rep_reg, rep_next;
    logic [3:0]  fl_reg, fl_next;
    logic [16:0] wu_reg, wu_next, hu_reg, hu_next;
    logic [31:0] tick_reg, tick_next, scl_reg, scl_next;
    logic [1:0]  sts_reg, sts_next;

    logic        b, fdone;
    logic [31:0] fv, acc_sh, base;
    logic [5:0]  nx;
    logic [7:0]  rep_dec;
    logic [16:0] mbc;

    always_comb begin
        zero_run_next = zero_run_reg; sh_next = sh_reg; nb_next = nb_reg;
        step_next = step_reg; phase_next = phase_reg; pz_next = pz_reg;
        acc_next = acc_reg; rem_next = rem_reg; rep_next = rep_reg;
        fl_next = fl_reg; wu_next = wu_reg; hu_next = hu_reg;
        tick_next = tick_reg; scl_next = scl_reg; sts_next = sts_reg;
        b = sh_reg[7]; fdone = 1'b0; fv = '0; nx = step_reg + 6'd1;
        acc_sh = {acc_reg[30:0], b};
        base = '0; rep_dec = rep_reg - 8'd1;
        mbc = '0;

        if (cmd.load) begin
            if (zero_run_reg == 2'd2 && in_byte == 8'h03) begin
                zero_run_next = 2'd0;
            end else begin
                zero_run_next = (in_byte != 8'd0) ? 2'd0 :
                                (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
                sh_next = in_byte;
                nb_next = 4'd8;
            end
        end else if (cmd.shift && nb_reg != 4'd0) begin
            sh_next = {sh_reg[6:0], 1'b0};
            nb_next = nb_reg - 4'd1;
            if (step_reg < ST_DONE) begin
                if (step_bits(step_reg) != 6'd0) begin
                    acc_next = acc_sh;
                    rem_next = rem_reg - 6'd1;
                    if (rem_reg == 6'd1) begin fdone = 1'b1; fv = acc_sh; end
                end else if (!phase_reg) begin
                    if (!b && pz_reg < 6'(MAX_PREFIX_ZEROS)) begin
                        pz_next = pz_reg + 6'd1;
                    end else if (pz_reg == 6'd0) begin
                        fdone = 1'b1;
                    end else begin
                        phase_next = 1'b1; rem_next = pz_reg; acc_next = '0;
                    end
                end else begin
                    acc_next = acc_sh;
                    rem_next = rem_reg - 6'd1;
                    if (rem_reg == 6'd1) begin
                        base = (32'd1 << pz_reg[4:0]) - 32'd1;
                        fdone = 1'b1; fv = base + acc_sh;
                    end
                end
            end
        end

        mbc = (fv >= 32'd65535) ? 17'd65536 : 17'(fv + 32'd1);
        if (fdone) begin
            unique case (step_reg)
                ST_HDR: if (fv[4:0] != 5'd7) begin sts_next = STS_NOT_SPS; nx = ST_DONE; end
                ST_PROFILE: if (fv == 32'd100 || fv == 32'd110 || fv == 32'd122 ||
                                fv == 32'd144) fl_next[FL_HIGH] = 1'b1;
                ST_SPSID: nx = fl_reg[FL_HIGH] ? ST_CHROMA : ST_LOG2FN;
                ST_CHROMA: if (fv == 32'd3) begin
                        fl_next[FL_C444] = 1'b1; nx = ST_RESCOL;
                    end else nx = ST_BDL;
                ST_SMAT: if (fv != 0) begin
                        rep_next = fl_reg[FL_C444] ? 8'd12 : 8'd8; nx = ST_SLIST;
                    end else nx = ST_LOG2FN;
                ST_SLIST: if (fv != 0) begin sts_next = STS_SCALING; nx = ST_DONE; end
                    else begin
                        rep_next = rep_dec; nx = (rep_dec == 0) ? ST_LOG2FN : ST_SLIST;
                    end
                ST_POCT: nx = (fv == 0) ? ST_POCLSB : (fv == 1) ? ST_DPOAZ : ST_NREF;
                ST_POCLSB: nx = ST_NREF;
                ST_NCYC: begin
                    rep_next = (fv > 32'(MAX_POC_CYCLE)) ? 8'(MAX_POC_CYCLE) : fv[7:0];
                    nx = (fv == 0) ? ST_NREF : ST_OFFREF;
                end
                ST_OFFREF, ST_CROPOFF, ST_CLOCV: begin
                    rep_next = rep_dec;
                    if (rep_dec == 0)
                        nx = (step_reg == ST_OFFREF) ? ST_NREF :
                             (step_reg == ST_CROPOFF) ? ST_VUI : ST_TIM;
                    else nx = step_reg;
                end
                ST_WIDTH: wu_next = mbc;
                ST_HEIGHT: begin hu_next = mbc; fl_next[FL_SIZE] = 1'b1; end
                ST_FMBS: nx = (fv != 0) ? ST_D8 : ST_MBAFF;
                ST_CROP: if (fv != 0) begin rep_next = 8'd4; nx = ST_CROPOFF; end
                    else nx = ST_VUI;
                ST_VUI: nx = (fv != 0) ? ST_ARP : ST_DONE;
                ST_ARP: nx = (fv != 0) ? ST_ARIDC : ST_OSP;
                ST_ARIDC: nx = (fv == 32'd255) ? ST_SARW : ST_OSP;
                ST_OSP: nx = (fv != 0) ? ST_OSA : ST_VST;
                ST_VST: nx = (fv != 0) ? ST_VFMT : ST_CLOC;
                ST_CDP: nx = (fv != 0) ? ST_COLOR : ST_CLOC;
                ST_CLOC: if (fv != 0) begin rep_next = 8'd2; nx = ST_CLOCV; end
                    else nx = ST_TIM;
                ST_TIM: nx = (fv != 0) ? ST_TICK : ST_DONE;
                ST_TICK: tick_next = fv;
                ST_SCALE: begin scl_next = fv; fl_next[FL_RATE] = 1'b1; nx = ST_DONE; end
                default: ;
            endcase
            step_next = nx; phase_next = 1'b0; pz_next = '0; acc_next = '0;
            rem_next = step_bits(nx);
        end

        if (cmd.clear) begin
            zero_run_next = '0; nb_next = '0; step_next = ST_HDR; phase_next = 1'b0;
            pz_next = '0; acc_next = '0; rem_next = step_bits(ST_HDR); rep_next = '0;
            fl_next = '0; wu_next = '0; hu_next = '0; tick_next = '0; scl_next = '0;
            sts_next = STS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg <= '0; nb_reg <= '0; step_reg <= ST_HDR; phase_reg <= 1'b0;
            pz_reg <= '0; acc_reg <= '0; rem_reg <= step_bits(ST_HDR); rep_reg <= '0;
            fl_reg <= '0; wu_reg <= '0; hu_reg <= '0; tick_reg <= '0; scl_reg <= '0;
            sts_reg <= STS_OK;
        end else begin
            zero_run_reg <= zero_run_next; nb_reg <= nb_next; step_reg <= step_next;
            phase_reg <= phase_next; pz_reg <= pz_next; acc_reg <= acc_next;
            rem_reg <= rem_next; rep_reg <= rep_next; fl_reg <= fl_next;
            wu_reg <= wu_next; hu_reg <= hu_next; tick_reg <= tick_next;
            scl_reg <= scl_next; sts_reg <= sts_next;
        end
        sh_reg <= sh_next;
    end

    logic [1:0] fin_sts;
    assign fin_sts   = (sts_reg == STS_OK && !fl_reg[FL_SIZE]) ? STS_TRUNC : sts_reg;
    assign status    = fin_sts;
    // 65536*16 = 2^20 fits in 21 bits
    assign width_px  = (fin_sts == STS_OK) ? {wu_reg, 4'd0} : '0;
    assign height_px = (fin_sts == STS_OK) ? {hu_reg, 4'd0} : '0;
    assign rate_ok   = fin_sts == STS_OK && fl_reg[FL_RATE] && tick_reg != 0;
    assign scale     = scl_reg;
    assign tick2     = {tick_reg, 1'b0};
    assign bits_left = nb_reg;

    property p_done_hold;
        @(posedge aclk) disable iff (!aresetn)
            (step_reg >= ST_DONE && !cmd.clear) |-> step_next == step_reg;
    endproperty
    assert property (p_done_hold) else $error("syntax walker left its end state");
    property p_zrun;
        @(posedge aclk) disable iff (!aresetn) zero_run_reg != 2'd3;
    endproperty
    assert property (p_zrun) else $error("zero run out of range");
    property p_prefix;
        @(posedge aclk) disable iff (!aresetn) pz_reg <= 6'(MAX_PREFIX_ZEROS);
    endproperty
    assert property (p_prefix) else $error("prefix count overflow");
endmodule
`default_nettype wire

/* sv/sps_ctrl.sv */
// Controller FSM: takes a byte, shifts 8 bits through the walker, on the last
// byte runs the divider and holds the result in an output register. Uses sps_pkg.
`default_nettype none
module sps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic             in_last,
    input  wire logic [3:0]       bits_left,
    input  wire logic             div_busy,
    input  wire logic             out_fire,
    output sps_pkg::sps_cmd_t     cmd,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic                  capture
);
    import sps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_SHIFT = 3'd1, S_DIV0 = 3'd2,
                           S_DIV = 3'd3, S_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        capture    = 1'b0;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                cmd.load = 1'b1; last_next = in_last; state_next = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (bits_left <= 4'd1) state_next = last_reg ? S_DIV0 : S_IDLE;
            end
            S_DIV0: begin cmd.div_start = 1'b1; state_next = S_DIV; end
            S_DIV: if (!div_busy) begin
                capture = 1'b1; cmd.clear = 1'b1; state_next = S_OUT;
            end
            S_OUT: if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    property p_excl;
        @(posedge aclk) disable iff (!aresetn) !(in_ready && out_valid);
    endproperty
    assert property (p_excl) else $error("input and output both open");
    property p_cap;
        @(posedge aclk) disable iff (!aresetn) capture |=> out_valid;
    endproperty
    assert property (p_cap) else $error("result not presented after capture");
    property p_div;
        @(posedge aclk) disable iff (!aresetn) cmd.div_start |=> div_busy;
    endproperty
    assert property (p_div) else $error("divider did not start");
endmodule
`default_nettype wire

/* sv/h264_sps_size_rate_parser_unit.sv */
// H.264 SPS size and rate parser, top level. Each accepted byte is shifted through
// the syntax walker one bit a cycle; a dropped 0x03 byte feeds it no bits.
// After the last byte the divider is loaded and steps through the quotient bits, then
// the result is captured and shown; no byte is taken until that item is accepted.
// Sync active-low reset returns the parser to the NAL header field.
// Uses sps_pkg, sps_ctrl, sps_datapath, sps_div.
`default_nettype none
module h264_sps_size_rate_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // status, frame_width, frame_height, frame_rate, rate_valid
);
    import sps_pkg::*;

    sps_cmd_t    cmd;
    logic [3:0]  bits_left;
    logic [1:0]  status;
    logic [20:0] wpx, hpx;
    logic [31:0] scale, quo;
    logic [32:0] tick2;
    logic        rate_ok, div_busy, capture;
    logic [75:0] res_reg;

    sps_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire(s_tvalid && s_tready), .in_last(s_tlast), .bits_left,
        .div_busy, .out_fire(m_tvalid && m_tready),
        .cmd, .in_ready(s_tready), .out_valid(m_tvalid), .capture
    );

    sps_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_byte(s_tdata), .bits_left,
        .status, .width_px(wpx), .height_px(hpx), .scale, .tick2, .rate_ok
    );

    sps_div u_div (
        .aclk, .aresetn, .start(cmd.div_start), .dividend(scale),
        .divisor(tick2), .busy(div_busy), .quotient(quo)
    );

    always_ff @(posedge aclk) begin
        if (capture)
            res_reg <= {rate_ok, rate_ok ? quo[30:0] : 31'd0, hpx, wpx, status};
    end

    assign m_tdata = {4'd0, res_reg};
endmodule
`default_nettype wire

/* tb/sv/tb_h264_sps_size_rate_parser_unit.sv */
// Testbench for h264_sps_size_rate_parser_unit: drives SPS NAL units byte by byte,
// predicts status, size and rate per unit, checks each result. Uses sps_pkg.
`timescale 1ns / 1ps
module tb_h264_sps_size_rate_parser_unit;
    import sps_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } sps_byte_t;

    // lowest bits last: matches the result bus layout
    typedef struct packed {
        logic        rate_ok;
        logic [30:0] rate;
        logic [20:0] height;
        logic [20:0] width;
        logic [1:0]  status;
    } sps_info_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;

    h264_sps_size_rate_parser_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial forever #4 aclk = ~aclk;

    sps_byte_t pending_bytes[$];
    sps_info_t expected_info[$];
    int  send_idle_pct = 0, recv_stall_pct = 0;
    bit  hold_send = 0;
    int  errors = 0, units_checked = 0, bytes_sent = 0, quiet_cycles = 0;
    bit  timed_out = 0;

    // predictor state
    logic [1:0]  p_zrun;
    logic [5:0]  p_step, p_pz, p_left;
    logic        p_gph;
    logic [31:0] p_acc;
    logic [7:0]  p_rep;
    logic [3:0]  p_flags;
    logic [16:0] p_wu, p_hu;
    logic [31:0] p_tick, p_scale;
    logic [1:0]  p_status;

    function automatic logic [5:0] width_of(logic [5:0] s);
        case (s)
            ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_ARIDC: return 8;
            ST_SARW, ST_SARH: return 16;
            ST_VFMT: return 3;
            ST_COLOR: return 24;
            ST_TICK, ST_SCALE: return 32;
            ST_SPSID, ST_CHROMA, ST_BDL, ST_BDC, ST_LOG2FN, ST_POCT, ST_POCLSB,
            ST_ONRP, ST_OTTB, ST_NCYC, ST_OFFREF, ST_NREF, ST_WIDTH, ST_HEIGHT,
            ST_CROPOFF, ST_CLOCV: return 0;
            default: return 1;
        endcase
    endfunction

    task automatic enter_step(logic [5:0] s);
        p_step = s; p_gph = 0; p_pz = 0; p_acc = 0; p_left = width_of(s);
    endtask

    function automatic logic [16:0] mbs(logic [31:0] v);
        return (v >= 65535) ? 17'd65536 : 17'(v + 1);
    endfunction

    task automatic clear_parser();
        p_zrun = 0; p_rep = 0; p_flags = 0; p_wu = 0; p_hu = 0;
        p_tick = 0; p_scale = 0; p_status = STS_OK;
        enter_step(ST_HDR);
        p_left = 0;
    endtask

    task automatic close_field(logic [31:0] v);
        logic [5:0] nx;
        nx = p_step + 1;
        case (p_step)
            ST_HDR: if (v[4:0] != 7) begin
                p_status = STS_NOT_SPS; nx = ST_DONE;
            end
            ST_PROFILE: if (v == 100 || v == 110 || v == 122 || v == 144)
                p_flags[FL_HIGH] = 1;
            ST_SPSID: nx = p_flags[FL_HIGH] ? ST_CHROMA : ST_LOG2FN;
            ST_CHROMA: if (v == 3) begin
                p_flags[FL_C444] = 1; nx = ST_RESCOL;
            end else nx = ST_BDL;
            ST_SMAT: if (v != 0) begin
                p_rep = p_flags[FL_C444] ? 12 : 8; nx = ST_SLIST;
            end else nx = ST_LOG2FN;
            ST_SLIST: if (v != 0) begin
                p_status = STS_SCALING; nx = ST_DONE;
            end else begin
                p_rep--; nx = (p_rep == 0) ? ST_LOG2FN : ST_SLIST;
            end
            ST_POCT: nx = (v == 0) ? ST_POCLSB : (v == 1) ? ST_DPOAZ : ST_NREF;
            ST_POCLSB: nx = ST_NREF;
            ST_NCYC: begin
                p_rep = (v > MAX_POC_CYCLE) ? 8'(MAX_POC_CYCLE) : v[7:0];
                nx = (p_rep == 0) ? ST_NREF : ST_OFFREF;
            end
            ST_OFFREF: begin
                p_rep--; nx = (p_rep == 0) ? ST_NREF : ST_OFFREF;
            end
            ST_WIDTH: p_wu = mbs(v);
            ST_HEIGHT: begin
                p_hu = mbs(v); p_flags[FL_SIZE] = 1;
            end
            ST_FMBS: nx = v ? ST_D8 : ST_MBAFF;
            ST_CROP: if (v != 0) begin
                p_rep = 4; nx = ST_CROPOFF;
            end else nx = ST_VUI;
            ST_CROPOFF: begin
                p_rep--; nx = (p_rep == 0) ? ST_VUI : ST_CROPOFF;
            end
            ST_VUI: nx = v ? ST_ARP : ST_DONE;
            ST_ARP: nx = v ? ST_ARIDC : ST_OSP;
            ST_ARIDC: nx = (v == 255) ? ST_SARW : ST_OSP;
            ST_OSP: nx = v ? ST_OSA : ST_VST;
            ST_VST: nx = v ? ST_VFMT : ST_CLOC;
            ST_CDP: nx = v ? ST_COLOR : ST_CLOC;
            ST_CLOC: if (v != 0) begin
                p_rep = 2; nx = ST_CLOCV;
            end else nx = ST_TIM;
            ST_CLOCV: begin
                p_rep--; nx = (p_rep == 0) ? ST_TIM : ST_CLOCV;
            end
            ST_TIM: nx = v ? ST_TICK : ST_DONE;
            ST_TICK: p_tick = v;
            ST_SCALE: begin
                p_scale = v; p_flags[FL_RATE] = 1; nx = ST_DONE;
            end
            default: ;
        endcase
        enter_step(nx);
    endtask

    task automatic take_bit(logic b);
        logic [31:0] base;
        if (p_step >= ST_DONE) return;
        if (width_of(p_step) != 0) begin
            p_acc = {p_acc[30:0], b};
            p_left--;
            if (p_left == 0) close_field(p_acc);
        end else if (!p_gph) begin
            if (!b && p_pz < MAX_PREFIX_ZEROS) p_pz++;
            else if (p_pz == 0) close_field(0);
            else begin
                p_gph = 1; p_left = p_pz; p_acc = 0;
            end
        end else begin
            p_acc = {p_acc[30:0], b};
            p_left--;
            if (p_left == 0) begin
                base = (32'd1 << p_pz[4:0]) - 1;
                close_field(base + p_acc);
            end
        end
    endtask

    task automatic predict_byte(sps_byte_t it);
        sps_info_t r;
        logic [1:0] st;
        if (p_step == ST_HDR && p_left == 0) enter_step(ST_HDR);
        if (p_zrun >= 2 && it.data == 8'h03) p_zrun = 0;
        else begin
            p_zrun = (it.data == 0) ? ((p_zrun >= 2) ? 2'd2 : p_zrun + 1) : 2'd0;
            for (int i = 7; i >= 0; i--) take_bit(it.data[i]);
        end
        if (!it.last) return;
        r = '0;
        st = p_status;
        if (st == STS_OK && !p_flags[FL_SIZE]) st = STS_TRUNC;
        r.status = st;
        if (st == STS_OK) begin
            r.width = 21'(p_wu * 16);
            r.height = 21'(p_hu * 16);
            if (p_flags[FL_RATE] && p_tick != 0) begin
                r.rate = 31'(64'(p_scale) / (64'd2 * p_tick));
                r.rate_ok = 1;
            end
        end
        expected_info.push_back(r);
        clear_parser();
    endtask

    // ---- stimulus building: a bit writer
    bit sbits[$];
    task automatic put(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) sbits.push_back(v[i]);
    endtask
    task automatic put_ue(logic [31:0] v);
        logic [32:0] x;
        int n;
        x = 33'(v) + 1;
        n = 0;
        for (int i = 32; i >= 0; i--) if (x[i] && n == 0) n = i;
        put(0, n);
        put(x[31:0] | (32'd1 << n), n + 1);
    endtask

    // turn bits into bytes with emulation prevention, optionally corrupt or truncate them, push with last on final byte
    task automatic emit_unit(bit corrupt);
        logic [7:0] b;
        int zr, nb;
        sps_byte_t q[$];
        while (sbits.size() % 8) sbits.push_back($urandom_range(0, 1));
        zr = 0;
        while (sbits.size()) begin
            for (int i = 0; i < 8; i++) b[7 - i] = sbits.pop_front();
            if (corrupt && $urandom_range(0, 15) == 0) b = $urandom;
            if (zr >= 2 && b <= 3) begin
                q.push_back('{8'h03, 1'b0}); zr = 0;
            end
            q.push_back('{b, 1'b0});
            zr = (b == 0) ? zr + 1 : 0;
        end
        if (corrupt && $urandom_range(0, 3) == 0) begin
            nb = $urandom_range(1, q.size());
            while (q.size() > nb) void'(q.pop_back());
        end
        if (q.size() && $urandom_range(0, 9) == 0) q.push_back('{8'h03, 1'b0});
        q[$].last = 1;
        foreach (q[i]) pending_bytes.push_back(q[i]);
    endtask

    task automatic rand_ue(int maxbits);
        put_ue($urandom_range(0, (1 << $urandom_range(0, maxbits)) - 1));
    endtask

    // an SPS with random content; knobs select corner cases, including a bad header and corruption
    task automatic build_sps(int kind);
        int prof, chroma, poct, ncyc;
        logic [31:0] w, h;
        sbits.delete();
        put((kind == 1) ? $urandom_range(0, 255) : {3'($urandom_range(0, 7)), 5'd7}, 8);
        case ($urandom_range(0, 3))
            0: prof = 66; 1: prof = 100; 2: prof = 144; default: prof = $urandom_range(0, 255);
        endcase
        put(prof, 8); put($urandom, 8); put($urandom, 8);
        rand_ue(5);
        if (prof == 100 || prof == 110 || prof == 122 || prof == 144) begin
            chroma = $urandom_range(0, 3);
            put_ue(chroma);
            if (chroma == 3) put($urandom, 1);
            rand_ue(3); rand_ue(3); put($urandom, 1);
            if (kind == 2) begin
                put(1, 1);
                for (int i = 0; i < (chroma == 3 ? 12 : 8); i++)
                    put(($urandom_range(0, 5) == 0), 1);
            end else put(0, 1);
        end
        rand_ue(4);
        poct = $urandom_range(0, 3);
        put_ue(poct);
        if (poct == 0) rand_ue(4);
        else if (poct == 1) begin
            put($urandom, 1); rand_ue(8); rand_ue(8);
            ncyc = (kind == 3) ? $urandom_range(250, 300) : $urandom_range(0, 5);
            put_ue(ncyc);
            for (int i = 0; i < (ncyc > 255 ? 255 : ncyc); i++) rand_ue(6);
        end
        rand_ue(4); put($urandom, 1);
        w = (kind == 4) ? $urandom_range(65530, 70000) : $urandom_range(0, 255);
        h = (kind == 4) ? 32'hFFFF_FFFE : $urandom_range(0, 255);
        put_ue(w); put_ue(h);
        if ($urandom_range(0, 1)) put(1, 1);
        else begin
            put(0, 1); put($urandom, 1);
        end
        put($urandom, 1);
        if ($urandom_range(0, 1)) begin
            put(1, 1); repeat (4) rand_ue(5);
        end else put(0, 1);
        if ($urandom_range(0, 5) == 0) put(0, 1);
        else begin
            put(1, 1);
            if ($urandom_range(0, 1)) begin
                put(1, 1);
                if ($urandom_range(0, 1)) begin
                    put(255, 8); put($urandom, 16); put($urandom, 16);
                end else put($urandom_range(0, 254), 8);
            end else put(0, 1);
            if ($urandom_range(0, 1)) begin
                put(1, 1); put($urandom, 1);
            end else put(0, 1);
            if ($urandom_range(0, 1)) begin
                put(1, 1); put($urandom, 3); put($urandom, 1);
                if ($urandom_range(0, 1)) begin
                    put(1, 1); put($urandom, 24);
                end else put(0, 1);
            end else put(0, 1);
            if ($urandom_range(0, 1)) begin
                put(1, 1); rand_ue(4); rand_ue(4);
            end else put(0, 1);
            if ($urandom_range(0, 5) == 0) put(0, 1);
            else begin
                put(1, 1);
                case ($urandom_range(0, 3))
                    0: put(0, 32);
                    1: put(32'hFFFF_FFFF, 32);
                    default: put($urandom_range(1, 5000), 32);
                endcase
                put(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom, 32);
            end
        end
        put(1, 1);
        emit_unit(kind == 5);
    endtask

    task automatic add_raw(int n);
        for (int i = 0; i < n; i++) pending_bytes.push_back('{8'($urandom), 1'b0});
        pending_bytes[$].last = 1;
    endtask

    // ---- driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) bytes_sent <= bytes_sent + 1;
            if (pending_bytes.size() && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
                {s_tdata, s_tlast} <= pending_bytes.pop_front();
                s_tvalid <= 1;
            end else s_tvalid <= 0;
        end
    end

    // predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) predict_byte('{s_tdata, s_tlast});
    end

    // ---- monitor
    always @(posedge aclk) begin
        sps_info_t got, exp_r;
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                got = m_tdata[75:0];
                units_checked <= units_checked + 1;
                if (expected_info.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_tdata);
                end else begin
                    exp_r = expected_info.pop_front();
                    if (got.status !== exp_r.status)
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    if (got.width !== exp_r.width)
                        $display("%0t: width exp %0d got %0d", $time, exp_r.width, got.width);
                    if (got.height !== exp_r.height)
                        $display("%0t: height exp %0d got %0d", $time, exp_r.height, got.height);
                    if (got.rate !== exp_r.rate)
                        $display("%0t: rate exp %0d got %0d", $time, exp_r.rate, got.rate);
                    if (got.rate_ok !== exp_r.rate_ok)
                        $display("%0t: rate_valid exp %0d got %0d", $time, exp_r.rate_ok,
                                 got.rate_ok);
                    if (got !== exp_r) errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("FAIL h264_sps_size_rate_parser_unit");
            $finish;
        end
    end

    task automatic drain();
        while (pending_bytes.size() || s_tvalid || expected_info.size()) @(posedge aclk);
    endtask

    initial begin
        clear_parser();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        // directed: plain, not-SPS, scaling, long POC cycle, huge size, truncated, raw
        build_sps(0); build_sps(1); build_sps(2); build_sps(3); build_sps(4);
        pending_bytes.push_back('{8'h67, 1'b0}); pending_bytes.push_back('{8'hFF, 1'b1});
        pending_bytes.push_back('{8'h00, 1'b0}); pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'h03, 1'b1});
        // long prefix: 32+ zero bits in an exp-Golomb field
        pending_bytes.push_back('{8'h67, 1'b0}); pending_bytes.push_back('{8'h64, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0}); pending_bytes.push_back('{8'h00, 1'b0});
        repeat (5) pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b1});
        drain();
        // sender pause: hold a queued unit back, then release it
        hold_send = 1;
        build_sps(0);
        repeat (20) @(posedge aclk);
        hold_send = 0;
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 24 : 49) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 24 : 49) : 0;
            for (int u = 0; u < 6; u++) begin
                case ($urandom_range(0, 9))
                    0: build_sps(1); 1: build_sps(2); 2: build_sps(3);
                    3: build_sps(4); 4: build_sps(5); 5: add_raw($urandom_range(1, 12));
                    default: build_sps(0);
                endcase
            end
            drain();
        end
        repeat (100) @(posedge aclk);
        $display("Sent %0d bytes of SPS units, %0d results checked under four flow-control phases.",
                 bytes_sent, units_checked);
        if (errors == 0 && expected_info.size() == 0)
            $display("PASS h264_sps_size_rate_parser_unit");
        else
            $display("FAIL h264_sps_size_rate_parser_unit");
        $finish;
    end
endmodule
